@@ hdl/ttm_pkg.sv @@
// Shared constants, configuration type and helper functions of the temperature monitor.
package ttm_pkg;

  localparam int COUNT_BITS   = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int SUM_BITS     = COUNT_BITS + SAMPLE_BITS;
  localparam int PCT_BITS     = COUNT_BITS + 14;
  localparam int DIV_BITS     = (SUM_BITS > PCT_BITS) ? SUM_BITS : PCT_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
  localparam int CMP_BITS     = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;

  localparam int ADDR_BITS    = 4;
  localparam int DATA_BITS    = 32;

  localparam logic [1:0] REG_UPPER_LIMIT      = 2'd0;
  localparam logic [1:0] REG_VALID_LOW        = 2'd1;
  localparam logic [1:0] REG_VALID_HIGH       = 2'd2;
  localparam logic [1:0] REG_ALARM_RUN_LENGTH = 2'd3;

  localparam logic [14:0] UPPER_LIMIT_RST = 15'd1280;
  localparam logic [15:0] VALID_LOW_RST   = 16'hFCE0;  // -800
  localparam logic [15:0] VALID_HIGH_RST  = 16'd2400;
  localparam logic [3:0]  RUN_LENGTH_RST  = 4'd3;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [2:0] KIND_ABOVE      = 3'd1;
  localparam logic [2:0] KIND_REJECTED   = 3'd2;
  localparam logic [2:0] KIND_ALARM_END  = 3'd3;
  localparam logic [2:0] KIND_MANUAL_END = 3'd4;
  localparam logic [2:0] KIND_IGNORED    = 3'd5;
  localparam logic [2:0] KIND_FULL       = 3'd6;

  localparam logic [13:0] PCT_SCALE = 14'd10000;

  typedef struct packed {
    logic [14:0] upper_limit;
    logic [15:0] valid_low;
    logic [15:0] valid_high;
    logic [3:0]  alarm_run_length;
  } cfg_t;

  // sign-extend or truncate a stored sample to the 16-bit report field
  function automatic logic [15:0] to_s16(input logic [SAMPLE_BITS-1:0] v);
    logic signed [CMP_BITS-1:0] w;
    w = CMP_BITS'($signed(v));
    return w[15:0];
  endfunction

  // low 16 bits of a count, zero-extended when the count is narrower
  function automatic logic [15:0] cnt16(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+15:0] w;
    w = (COUNT_BITS + 16)'(v);
    return w[15:0];
  endfunction

endpackage

@@ hdl/ttm_cfg.sv @@
// APB register file holding the monitor thresholds.
module ttm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ttm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [ttm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [ttm_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output ttm_pkg::cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_limit      <= ttm_pkg::UPPER_LIMIT_RST;
      cfg.valid_low        <= ttm_pkg::VALID_LOW_RST;
      cfg.valid_high       <= ttm_pkg::VALID_HIGH_RST;
      cfg.alarm_run_length <= ttm_pkg::RUN_LENGTH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ttm_pkg::REG_UPPER_LIMIT:      cfg.upper_limit      <= pwdata[14:0];
        ttm_pkg::REG_VALID_LOW:        cfg.valid_low        <= pwdata[15:0];
        ttm_pkg::REG_VALID_HIGH:       cfg.valid_high       <= pwdata[15:0];
        ttm_pkg::REG_ALARM_RUN_LENGTH: cfg.alarm_run_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ttm_pkg::REG_UPPER_LIMIT:      prdata = ttm_pkg::DATA_BITS'(cfg.upper_limit);
      ttm_pkg::REG_VALID_LOW:        prdata = ttm_pkg::DATA_BITS'(cfg.valid_low);
      ttm_pkg::REG_VALID_HIGH:       prdata = ttm_pkg::DATA_BITS'(cfg.valid_high);
      ttm_pkg::REG_ALARM_RUN_LENGTH: prdata = ttm_pkg::DATA_BITS'(cfg.alarm_run_length);
      default:                       prdata = '0;
    endcase
  end

endmodule

@@ hdl/ttm_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module ttm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ttm_pkg::DIV_BITS-1:0]    dividend,
  input  logic [ttm_pkg::COUNT_BITS-1:0]  divisor,
  output logic                            done,
  output logic [ttm_pkg::DIV_BITS-1:0]    quotient
);

  localparam logic [ttm_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
    ttm_pkg::DIV_CNT_BITS'(ttm_pkg::DIV_BITS - 1);

  logic                                busy;
  logic [ttm_pkg::DIV_CNT_BITS-1:0]    cnt;
  logic [ttm_pkg::COUNT_BITS-1:0]      rem;
  logic [ttm_pkg::COUNT_BITS-1:0]      dsr;
  logic [ttm_pkg::COUNT_BITS:0]        rem_sh;
  logic [ttm_pkg::COUNT_BITS:0]        diff;
  logic [ttm_pkg::COUNT_BITS-1:0]      rem_next;
  logic                                q_bit;

  // quotient bits shift in from the bottom as dividend bits leave the top
  always_comb begin
    rem_sh = {rem, quotient[ttm_pkg::DIV_BITS-1]};
    diff   = rem_sh - {1'b0, dsr};
    q_bit  = !diff[ttm_pkg::COUNT_BITS];
    rem_next = q_bit ? diff[ttm_pkg::COUNT_BITS-1:0] : rem_sh[ttm_pkg::COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[ttm_pkg::DIV_BITS-2:0], q_bit};
      rem      <= rem_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> dsr != '0)
    else $error("division by zero");
`endif

endmodule

@@ hdl/temperature_threshold_monitor_top.sv @@
// Temperature threshold monitor: statistics, alarm run tracking and end-of-session report.
// A sample or ignored item's result is registered as it is taken; a restart yields none.
// An end report (manual or alarm) with samples runs the shared divider twice, mean then
// percentage, and no item is taken until it is done; an end with no samples is reported directly.
// Synchronous active-high reset clears statistics, sequencer and output valid; thresholds
// return to 1280, -800, 2400 and run length 3.
module temperature_threshold_monitor_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ttm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [ttm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [ttm_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic signed [15:0]             sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     kind,
  output logic [3:0]                     run_length,
  output logic [15:0]                    reading_count,
  output logic signed [15:0]             mean_value,
  output logic signed [15:0]             max_value,
  output logic signed [15:0]             min_value,
  output logic [15:0]                    above_count,
  output logic [13:0]                    above_percent,
  output logic                           stats_valid
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MEAN_GO   = 3'd1;
  localparam logic [2:0] S_MEAN_WAIT = 3'd2;
  localparam logic [2:0] S_PCT_GO    = 3'd3;
  localparam logic [2:0] S_PCT_WAIT  = 3'd4;

  localparam int CB = ttm_pkg::COUNT_BITS;
  localparam int SB = ttm_pkg::SAMPLE_BITS;
  localparam int WB = ttm_pkg::SUM_BITS;
  localparam int DB = ttm_pkg::DIV_BITS;
  localparam int XB = ttm_pkg::CMP_BITS;
  localparam int PB = ttm_pkg::PCT_BITS;

  ttm_pkg::cfg_t cfg;

  logic [2:0]    state;
  logic [CB-1:0] sample_total, sample_total_next;
  logic [WB-1:0] sample_sum, sample_sum_next;
  logic [SB-1:0] largest, largest_next;
  logic [SB-1:0] smallest, smallest_next;
  logic [CB-1:0] over_total, over_total_next;
  logic [3:0]    over_run, over_run_next;
  logic          session_ended, session_ended_next;
  logic [2:0]    rep_kind, rep_kind_next;
  logic [DB-1:0] mean_q;
  logic [PB-1:0] pct_dvd;

  logic          acc;
  logic          res_load;
  logic          go_report;
  logic [2:0]    res_kind;
  logic [SB-1:0] t_smp;
  logic signed [XB-1:0] t_ext, lo_ext, hi_ext, up_ext, large_ext, small_ext;
  logic          in_win;
  logic          above;
  logic [3:0]    run_inc;
  logic          have_next;
  logic [WB-1:0] sum_mag;
  logic [DB-1:0] mean_fix;

  logic          div_start;
  logic [DB-1:0] div_dividend;
  logic          div_done;
  logic [DB-1:0] div_q;

  ttm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sample_total),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  assign t_smp     = sample[SB-1:0];
  assign t_ext     = XB'($signed(t_smp));
  assign lo_ext    = XB'($signed(cfg.valid_low));
  assign hi_ext    = XB'($signed(cfg.valid_high));
  assign up_ext    = XB'($signed({1'b0, cfg.upper_limit}));
  assign large_ext = XB'($signed(largest));
  assign small_ext = XB'($signed(smallest));
  assign in_win    = (t_ext >= lo_ext) && (t_ext <= hi_ext);
  assign above     = t_ext > up_ext;
  assign run_inc   = over_run + 4'd1;

  assign sum_mag   = sample_sum[WB-1] ? (~sample_sum + 1'b1) : sample_sum;
  assign mean_fix  = sample_sum[WB-1] ? (~mean_q + 1'b1) : mean_q;

  assign div_start    = (state == S_MEAN_GO) || (state == S_PCT_GO);
  assign div_dividend = (state == S_MEAN_GO) ? DB'(sum_mag) : DB'(pct_dvd);

  // item decode and statistics update
  always_comb begin
    sample_total_next  = sample_total;
    sample_sum_next    = sample_sum;
    largest_next       = largest;
    smallest_next      = smallest;
    over_total_next    = over_total;
    over_run_next      = over_run;
    session_ended_next = session_ended;
    rep_kind_next      = rep_kind;
    res_load           = 1'b0;
    go_report          = 1'b0;
    res_kind           = ttm_pkg::KIND_IGNORED;
    if (acc) begin
      priority if (opcode == ttm_pkg::OP_RESTART) begin
        sample_total_next  = '0;
        sample_sum_next    = '0;
        largest_next       = '0;
        smallest_next      = '0;
        over_total_next    = '0;
        over_run_next      = '0;
        session_ended_next = 1'b0;
      end else if (opcode == ttm_pkg::OP_UNUSED || session_ended) begin
        res_load = 1'b1;
        res_kind = ttm_pkg::KIND_IGNORED;
      end else if (opcode == ttm_pkg::OP_END) begin
        session_ended_next = 1'b1;
        if (sample_total == '0) begin
          res_load = 1'b1;
          res_kind = ttm_pkg::KIND_MANUAL_END;
        end else begin
          go_report     = 1'b1;
          rep_kind_next = ttm_pkg::KIND_MANUAL_END;
        end
      end else if (!in_win) begin
        res_load = 1'b1;
        res_kind = ttm_pkg::KIND_REJECTED;
      end else if (sample_total == '1) begin
        res_load = 1'b1;
        res_kind = ttm_pkg::KIND_FULL;
      end else begin
        sample_total_next = sample_total + 1'b1;
        sample_sum_next   = sample_sum + WB'($signed(t_smp));
        if (sample_total == '0) begin
          largest_next  = t_smp;
          smallest_next = t_smp;
        end else begin
          if (t_ext > large_ext) largest_next = t_smp;
          if (t_ext < small_ext) smallest_next = t_smp;
        end
        if (above) begin
          over_total_next = over_total + 1'b1;
          over_run_next   = run_inc;
          if (run_inc >= cfg.alarm_run_length) begin
            session_ended_next = 1'b1;
            go_report          = 1'b1;
            rep_kind_next      = ttm_pkg::KIND_ALARM_END;
          end else begin
            res_load = 1'b1;
            res_kind = ttm_pkg::KIND_ABOVE;
          end
        end else begin
          over_run_next = '0;
          res_load      = 1'b1;
          res_kind      = ttm_pkg::KIND_ACCEPTED;
        end
      end
    end
  end

  assign have_next = sample_total_next != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_total  <= '0;
      sample_sum    <= '0;
      largest       <= '0;
      smallest      <= '0;
      over_total    <= '0;
      over_run      <= '0;
      session_ended <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      sample_total  <= sample_total_next;
      sample_sum    <= sample_sum_next;
      largest       <= largest_next;
      smallest      <= smallest_next;
      over_total    <= over_total_next;
      over_run      <= over_run_next;
      session_ended <= session_ended_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (res_load) out_valid <= 1'b1;
          if (go_report) state <= S_MEAN_GO;
        end
        S_MEAN_GO:   state <= S_MEAN_WAIT;
        S_MEAN_WAIT: if (div_done) state <= S_PCT_GO;
        S_PCT_GO:    state <= S_PCT_WAIT;
        S_PCT_WAIT: begin
          if (div_done) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // report datapath and output item register
  always_ff @(posedge clk) begin
    rep_kind <= rep_kind_next;
    if (state == S_MEAN_GO) pct_dvd <= PB'(over_total) * PB'(ttm_pkg::PCT_SCALE);
    if (state == S_MEAN_WAIT && div_done) mean_q <= div_q;
    if (state == S_IDLE && res_load) begin
      kind          <= res_kind;
      run_length    <= over_run_next;
      reading_count <= ttm_pkg::cnt16(sample_total_next);
      mean_value    <= '0;
      max_value     <= have_next ? ttm_pkg::to_s16(largest_next) : 16'd0;
      min_value     <= have_next ? ttm_pkg::to_s16(smallest_next) : 16'd0;
      above_count   <= ttm_pkg::cnt16(over_total_next);
      above_percent <= '0;
      stats_valid   <= have_next;
    end else if (state == S_PCT_WAIT && div_done) begin
      kind          <= rep_kind;
      run_length    <= over_run;
      reading_count <= ttm_pkg::cnt16(sample_total);
      mean_value    <= mean_fix[15:0];
      max_value     <= ttm_pkg::to_s16(largest);
      min_value     <= ttm_pkg::to_s16(smallest);
      above_count   <= ttm_pkg::cnt16(over_total);
      above_percent <= div_q[13:0];
      stats_valid   <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_report_after_end: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> session_ended)
    else $error("report running without session end");
  a_report_has_samples: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (sample_total != '0))
    else $error("report started with empty statistics");
  a_over_le_total: assert property (@(posedge clk) disable iff (rst)
    over_total <= sample_total)
    else $error("above count exceeds sample count");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MEAN_WAIT || state == S_PCT_WAIT))
    else $error("divider result outside a wait state");
  a_no_load_while_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCT_WAIT && div_done) |-> !out_valid)
    else $error("report would overwrite a pending item");
`endif

endmodule

@@ test/tb_temperature_threshold_monitor_top.sv @@
// Self-checking testbench for the temperature threshold monitor: statistics, alarm and report.
`timescale 1ns / 100ps

module tb_temperature_threshold_monitor_top;

  localparam int SETTLE = 80;          // longer than one end report
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;
  localparam int COUNT_CAP = (1 << ttm_pkg::COUNT_BITS) - 1;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] temp;
  } sensor_item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  run;
    logic [15:0] count;
    logic [15:0] mean;
    logic [15:0] maxv;
    logic [15:0] minv;
    logic [15:0] above;
    logic [13:0] pct;
    logic        valid;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ttm_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [ttm_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [ttm_pkg::DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = ttm_pkg::OP_SAMPLE;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] kind;
  logic [3:0] run_length;
  logic [15:0] reading_count;
  logic signed [15:0] mean_value;
  logic signed [15:0] max_value;
  logic signed [15:0] min_value;
  logic [15:0] above_count;
  logic [13:0] above_percent;
  logic stats_valid;

  temperature_threshold_monitor_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .run_length(run_length), .reading_count(reading_count),
    .mean_value(mean_value), .max_value(max_value), .min_value(min_value),
    .above_count(above_count), .above_percent(above_percent), .stats_valid(stats_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sensor_item_t sensor_items[$];
  report_t due_reports[$];
  report_t want_rep;
  int error_count = 0;
  int cycles = 0;
  int rnd_count = 0;
  bit calm = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // register mirror
  int c_limit = 1280;
  int c_low = -800;
  int c_high = 2400;
  int c_alarm = 3;

  // session state of the monitor
  int unsigned s_count = 0;
  longint s_sum = 0;
  int s_hi = 0;
  int s_lo = 0;
  int unsigned s_over = 0;
  int unsigned s_run = 0;
  bit s_done = 1'b0;

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic report_t make_report(input logic [2:0] k, input bit with_stats);
    report_t r;
    longint m;
    longint p;
    m = 0;
    p = 0;
    if (with_stats && s_count != 0) begin
      m = s_sum / longint'(s_count);
      p = longint'(s_over) * 10000 / longint'(s_count);
    end
    r.kind  = k;
    r.run   = s_run[3:0];
    r.count = s_count[15:0];
    r.mean  = m[15:0];
    r.maxv  = (s_count != 0) ? s_hi[15:0] : 16'd0;
    r.minv  = (s_count != 0) ? s_lo[15:0] : 16'd0;
    r.above = s_over[15:0];
    r.pct   = p[13:0];
    r.valid = (s_count != 0);
    return r;
  endfunction

  // returns 1 when the item yields a report
  function automatic bit track_reading(input logic [1:0] op, input logic [15:0] raw,
                                       output report_t r);
    int t;
    if (op == ttm_pkg::OP_RESTART) begin
      s_count = 0;
      s_sum = 0;
      s_hi = 0;
      s_lo = 0;
      s_over = 0;
      s_run = 0;
      s_done = 1'b0;
      return 1'b0;
    end
    if (op == ttm_pkg::OP_UNUSED || s_done) begin
      r = make_report(ttm_pkg::KIND_IGNORED, 1'b0);
      return 1'b1;
    end
    if (op == ttm_pkg::OP_END) begin
      s_done = 1'b1;
      r = make_report(ttm_pkg::KIND_MANUAL_END, 1'b1);
      return 1'b1;
    end
    t = int'($signed(raw));
    if (t < c_low || t > c_high) begin
      r = make_report(ttm_pkg::KIND_REJECTED, 1'b0);
      return 1'b1;
    end
    if (s_count >= COUNT_CAP) begin
      r = make_report(ttm_pkg::KIND_FULL, 1'b0);
      return 1'b1;
    end
    s_count++;
    s_sum += t;
    if (s_count == 1) begin
      s_hi = t;
      s_lo = t;
    end else begin
      if (t > s_hi) s_hi = t;
      if (t < s_lo) s_lo = t;
    end
    if (t > c_limit) begin
      s_over++;
      s_run++;
      if (s_run >= c_alarm) begin
        s_done = 1'b1;
        r = make_report(ttm_pkg::KIND_ALARM_END, 1'b1);
      end else begin
        r = make_report(ttm_pkg::KIND_ABOVE, 1'b0);
      end
    end else begin
      s_run = 0;
      r = make_report(ttm_pkg::KIND_ACCEPTED, 1'b0);
    end
    return 1'b1;
  endfunction

  // sender
  always @(posedge clk) begin : sender
    report_t r;
    sensor_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (track_reading(opcode, sample, r)) due_reports.push_back(r);
      end
      if (!in_valid || in_ready) begin
        if (sensor_items.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
          it = sensor_items.pop_front();
          in_valid <= 1'b1;
          opcode <= it.op;
          sample <= it.temp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        flag_error($sformatf("report with nothing due, kind %0d", kind));
      end else begin
        want_rep = due_reports.pop_front();
        if (kind !== want_rep.kind)
          flag_error($sformatf("kind %0d, want %0d", kind, want_rep.kind));
        if (run_length !== want_rep.run)
          flag_error($sformatf("run_length %0d, want %0d", run_length, want_rep.run));
        if (reading_count !== want_rep.count)
          flag_error($sformatf("reading_count %0d, want %0d", reading_count, want_rep.count));
        if (mean_value !== want_rep.mean)
          flag_error($sformatf("mean_value %0d, want %0d", mean_value,
                               $signed(want_rep.mean)));
        if (max_value !== want_rep.maxv)
          flag_error($sformatf("max_value %0d, want %0d", max_value, $signed(want_rep.maxv)));
        if (min_value !== want_rep.minv)
          flag_error($sformatf("min_value %0d, want %0d", min_value, $signed(want_rep.minv)));
        if (above_count !== want_rep.above)
          flag_error($sformatf("above_count %0d, want %0d", above_count, want_rep.above));
        if (above_percent !== want_rep.pct)
          flag_error($sformatf("above_percent %0d, want %0d", above_percent, want_rep.pct));
        if (stats_valid !== want_rep.valid)
          flag_error($sformatf("stats_valid %0d, want %0d", stats_valid, want_rep.valid));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] op, input int temp);
    sensor_item_t it;
    it.op = op;
    it.temp = temp[15:0];
    sensor_items.push_back(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ttm_pkg::REG_UPPER_LIMIT: c_limit = int'(val[14:0]);
      ttm_pkg::REG_VALID_LOW: c_low = int'($signed(val[15:0]));
      ttm_pkg::REG_VALID_HIGH: c_high = int'($signed(val[15:0]));
      ttm_pkg::REG_ALARM_RUN_LENGTH: c_alarm = int'(val[3:0]);
      default: ;
    endcase
  endtask

  // upper data bits carry junk; only the register width counts
  task automatic set_limits(input int lim, input int low, input int high, input int alarm);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(ttm_pkg::REG_UPPER_LIMIT, {junk[31:15], lim[14:0]});
    junk = $urandom();
    write_reg(ttm_pkg::REG_VALID_LOW, {junk[31:16], low[15:0]});
    junk = $urandom();
    write_reg(ttm_pkg::REG_VALID_HIGH, {junk[31:16], high[15:0]});
    junk = $urandom();
    write_reg(ttm_pkg::REG_ALARM_RUN_LENGTH, {junk[31:4], alarm[3:0]});
  endtask

  // block idle: nothing queued, nothing offered, nothing due
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (sensor_items.size() != 0 || in_valid || due_reports.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly near the limit or inside the window, so runs and alarms happen
  function automatic int pick_temp();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (c_low <= c_high && sel < 45) begin
      v = c_limit - 8 + int'($urandom_range(16));
      if (v > c_high) v = c_high;
      if (v < c_low) v = c_low;
    end else if (c_low <= c_high && sel < 85) begin
      v = c_low + int'($urandom_range(c_high - c_low));
    end else begin
      v = int'($urandom_range(16'hFFFF));
    end
    return v;
  endfunction

  task automatic queue_session(input int len);
    int sel;
    push_item(ttm_pkg::OP_RESTART, $urandom());
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(99);
      if (sel < 88) push_item(ttm_pkg::OP_SAMPLE, pick_temp());
      else if (sel < 91) push_item(ttm_pkg::OP_END, $urandom());
      else push_item(ttm_pkg::OP_UNUSED, $urandom());
    end
    if ($urandom_range(99) < 60) push_item(ttm_pkg::OP_END, $urandom());
    rnd_count += len + 1;
  endtask

  initial begin : stimulus
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset limits: 1280 above, window -800..2400, run of 3
    push_item(ttm_pkg::OP_END, 0);        // end with nothing accepted
    push_item(ttm_pkg::OP_SAMPLE, 0);     // ignored after end
    push_item(ttm_pkg::OP_END, 0);
    push_item(ttm_pkg::OP_UNUSED, 16'hFFFF);
    push_item(ttm_pkg::OP_RESTART, 0);
    push_item(ttm_pkg::OP_SAMPLE, -800);  // window edges
    push_item(ttm_pkg::OP_SAMPLE, -801);
    push_item(ttm_pkg::OP_SAMPLE, 2400);
    push_item(ttm_pkg::OP_SAMPLE, 2401);  // rejected, run kept
    push_item(ttm_pkg::OP_SAMPLE, 1281);
    push_item(ttm_pkg::OP_SAMPLE, 1280);  // at limit, run cleared
    push_item(ttm_pkg::OP_SAMPLE, 32767);
    push_item(ttm_pkg::OP_SAMPLE, -32768);
    push_item(ttm_pkg::OP_SAMPLE, 1281);
    push_item(ttm_pkg::OP_SAMPLE, 2000);
    push_item(ttm_pkg::OP_SAMPLE, 1500);  // alarm
    push_item(ttm_pkg::OP_SAMPLE, 5);
    push_item(ttm_pkg::OP_UNUSED, 0);
    push_item(ttm_pkg::OP_RESTART, 0);
    push_item(ttm_pkg::OP_SAMPLE, -3);
    push_item(ttm_pkg::OP_SAMPLE, -4);
    push_item(ttm_pkg::OP_UNUSED, 0);
    push_item(ttm_pkg::OP_END, 0);        // negative mean truncates toward zero
    push_item(ttm_pkg::OP_RESTART, 0);
    wait_idle();

    for (int p = 0; p < 7 || rnd_count < 450; p++) begin
      case (p)
        0: set_limits(1280, -800, 2400, 3);
        1: set_limits(0, -32768, 32767, 1);
        2: set_limits(32767, -32768, 32767, 15);
        3: set_limits(0, -100, 100, 0);        // zero length acts as one
        4: set_limits(500, 100, -100, 2);      // empty window
        5: set_limits(25, -40, 40, 15);
        default: set_limits($urandom_range(3000), -int'($urandom_range(2000)),
                            $urandom_range(4000), $urandom_range(1, 15));
      endcase
      calm = (p == 5);
      n = rnd_count;
      while (rnd_count - n < 60) queue_session($urandom_range(2, 30));
      wait_idle();
    end
    calm = 1'b0;

    // receiver stalls while the sender keeps offering
    set_limits(32767, -32768, 32767, 15);
    push_item(ttm_pkg::OP_RESTART, 0);
    for (int i = 0; i < 150; i++) push_item(ttm_pkg::OP_SAMPLE, $urandom());
    push_item(ttm_pkg::OP_END, 0);
    hold_req++;
    wait_idle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
